[rtl/core/rtf_pkg.sv]
// Shared types, constants and helper functions for the raster timing core.
// Used by raster_timing_register_file_core and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rtf_pkg;

   // Event codes carried in the action field.
   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_READ    = 2'd1,
      ACT_WRITE   = 2'd2,
      ACT_CONSUME = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_CYCLES_PER_LINE = 1'b0,
      CSR_LINES_PER_FRAME = 1'b1
   } csr_index_type;

   localparam int CycleW     = 7;
   localparam int LineW      = 9;
   localparam int FrameW     = 32;
   localparam int IndexW     = 6;
   localparam int ByteW      = 8;
   localparam int ColorW     = 4;
   localparam int RegDepth   = 64;
   localparam int CsrDataW   = 9;

   localparam int ReqDataW   = 16;
   localparam int RspFieldsW = ByteW + 1 + LineW + CycleW + FrameW + 2 * ColorW;
   localparam int RspDataW   = ((RspFieldsW + 7) / 8) * 8;

   localparam logic [IndexW-1:0] RegControl    = 6'h11;
   localparam logic [IndexW-1:0] RegRaster     = 6'h12;
   localparam logic [IndexW-1:0] RegBorder     = 6'h20;
   localparam logic [IndexW-1:0] RegBackground = 6'h21;

   localparam logic [ByteW-1:0]  BorderResetValue     = 8'd6;
   localparam logic [ByteW-1:0]  BackgroundResetValue = 8'd14;

   localparam logic [CycleW-1:0] CyclesPerLineReset = 7'd65;
   localparam logic [LineW-1:0]  LinesPerFrameReset = 9'd263;

   // Register contents after reset, for entries never written since.
   function automatic logic [ByteW-1:0] reg_reset_value(input logic [IndexW-1:0] idx);
      logic [ByteW-1:0] val;
      case (idx)
         RegBorder:     val = BorderResetValue;
         RegBackground: val = BackgroundResetValue;
         default:       val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

[rtl/core/raster_timing_register_file_core.sv]
// Raster timing counters and 64-entry byte register file of a video chip.
// Takes its types and constants from rtf_pkg.
//
// Usage:
//   Events arrive on the req_ stream (tdata: action, reg_index, write_data from
//   the lowest bit up) and each produces exactly one result on the rsp_ stream.
//   A tick advances the cycle, line and frame counters; a read returns a
//   register (0x12 and bit 7 of 0x11 show the raster line); a write stores a
//   register; a consume returns and clears the frame-done flag.
//   The csr_ port sets cycles per line (index 0) and lines per frame (index 1);
//   write it only while no event is in flight.
// Timing:
//   One event per cycle is sustained while rsp_tready stays high. An event passes
//   two register stages: the register file is read and written at the accept edge
//   into an input stage, and the counters are updated as the event moves from
//   that stage into the output register, which drives rsp_tvalid.
// Reset and stall:
//   Synchronous reset clears counters, flags and the register file valid bits
//   (registers 0x20 and 0x21 then read 6 and 14, all others zero). While
//   rsp_tready is low the output holds; one further event is taken into the
//   input stage, after which req_tready drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none

module raster_timing_register_file_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [1:0] action, [7:2] reg_index, [15:8] write_data
   input  wire logic [rtf_pkg::ReqDataW-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [7:0] read_data, [8] frame_done, [17:9] line number, [24:18] cycle within line,
   // [56:25] frame_count, [60:57] border nibble, [64:61] backdrop nibble, rest zero
   output logic [rtf_pkg::RspDataW-1:0]       rsp_tdata,
   input  wire logic                          csr_wen,
   input  wire logic                          csr_index,
   input  wire logic [rtf_pkg::CsrDataW-1:0]  csr_wdata
);

   // Request fields.
   rtf_pkg::action_type               req_action;
   logic [rtf_pkg::IndexW-1:0]        req_idx;
   logic [rtf_pkg::ByteW-1:0]         req_data;
   logic                              req_acc;
   logic                              a_adv;

   // Configuration.
   logic [rtf_pkg::CycleW-1:0]        cpl_ff;
   logic [rtf_pkg::LineW-1:0]         lpf_ff;

   // Register file, its valid bits and color shadows.
   logic [rtf_pkg::ByteW-1:0]         mem [rtf_pkg::RegDepth];
   logic [rtf_pkg::RegDepth-1:0]      mem_vld_ff;
   logic [rtf_pkg::ColorW-1:0]        border_ff;
   logic [rtf_pkg::ColorW-1:0]        border_in;
   logic [rtf_pkg::ColorW-1:0]        bgnd_ff;
   logic [rtf_pkg::ColorW-1:0]        bgnd_in;

   // Input stage.
   logic                              a_valid_ff;
   rtf_pkg::action_type               a_action_ff;
   logic [rtf_pkg::IndexW-1:0]        a_idx_ff;
   logic [rtf_pkg::ByteW-1:0]         a_mem_ff;
   logic                              a_hit_ff;
   logic [rtf_pkg::ColorW-1:0]        a_border_ff;
   logic [rtf_pkg::ColorW-1:0]        a_bgnd_ff;

   // Raster state.
   logic [rtf_pkg::CycleW-1:0]        cycle_ff;
   logic [rtf_pkg::CycleW-1:0]        cycle_in;
   logic [rtf_pkg::LineW-1:0]         line_ff;
   logic [rtf_pkg::LineW-1:0]         line_in;
   logic [rtf_pkg::FrameW-1:0]        frames_ff;
   logic [rtf_pkg::FrameW-1:0]        frames_in;
   logic                              flag_ff;
   logic                              flag_in;
   logic [rtf_pkg::CycleW:0]          cycle_inc;
   logic [rtf_pkg::LineW:0]           line_inc;
   logic [rtf_pkg::ByteW-1:0]         reg_base;
   logic [rtf_pkg::ByteW-1:0]         rd_in;
   logic                              done_in;

   // Output register.
   logic                              b_valid_ff;
   logic [rtf_pkg::ByteW-1:0]         b_rd_ff;
   logic                              b_done_ff;
   logic [rtf_pkg::LineW-1:0]         b_line_ff;
   logic [rtf_pkg::CycleW-1:0]        b_cycle_ff;
   logic [rtf_pkg::FrameW-1:0]        b_frames_ff;
   logic [rtf_pkg::ColorW-1:0]        b_border_ff;
   logic [rtf_pkg::ColorW-1:0]        b_bgnd_ff;

   assign req_action = rtf_pkg::action_type'(req_tdata[1:0]);
   assign req_idx    = req_tdata[7:2];
   assign req_data   = req_tdata[15:8];

   assign a_adv      = a_valid_ff && (!b_valid_ff || rsp_tready);
   assign req_tready = !a_valid_ff || a_adv;
   assign req_acc    = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cpl_ff <= rtf_pkg::CyclesPerLineReset;
         lpf_ff <= rtf_pkg::LinesPerFrameReset;
      end else if (csr_wen) begin
         unique case (rtf_pkg::csr_index_type'(csr_index))
            rtf_pkg::CSR_CYCLES_PER_LINE: cpl_ff <= csr_wdata[rtf_pkg::CycleW-1:0];
            rtf_pkg::CSR_LINES_PER_FRAME: lpf_ff <= csr_wdata;
            default:                      cpl_ff <= cpl_ff;
         endcase
      end
   end

   // Register file effects are resolved in the accept cycle, so a later read
   // always sees an earlier write.
   always_comb begin
      border_in = border_ff;
      bgnd_in   = bgnd_ff;
      if (req_action == rtf_pkg::ACT_WRITE) begin
         if (req_idx == rtf_pkg::RegBorder) begin
            border_in = req_data[rtf_pkg::ColorW-1:0];
         end
         if (req_idx == rtf_pkg::RegBackground) begin
            bgnd_in = req_data[rtf_pkg::ColorW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_mem_ff <= mem[req_idx];
         if (req_action == rtf_pkg::ACT_WRITE) begin
            mem[req_idx] <= req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
         border_ff  <= rtf_pkg::BorderResetValue[rtf_pkg::ColorW-1:0];
         bgnd_ff    <= rtf_pkg::BackgroundResetValue[rtf_pkg::ColorW-1:0];
         a_valid_ff <= 1'b0;
      end else begin
         if (req_acc) begin
            border_ff  <= border_in;
            bgnd_ff    <= bgnd_in;
            a_valid_ff <= 1'b1;
            if (req_action == rtf_pkg::ACT_WRITE) begin
               mem_vld_ff[req_idx] <= 1'b1;
            end
         end else if (a_adv) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_action_ff <= req_action;
         a_idx_ff    <= req_idx;
         a_hit_ff    <= mem_vld_ff[req_idx];
         a_border_ff <= border_in;
         a_bgnd_ff   <= bgnd_in;
      end
   end

   // Counter update and read substitution for the event in the input stage.
   always_comb begin
      cycle_in  = cycle_ff;
      line_in   = line_ff;
      frames_in = frames_ff;
      flag_in   = flag_ff;
      rd_in     = '0;
      done_in   = 1'b0;
      cycle_inc = {1'b0, cycle_ff} + 1'b1;
      line_inc  = {1'b0, line_ff} + 1'b1;
      reg_base  = a_hit_ff ? a_mem_ff : rtf_pkg::reg_reset_value(a_idx_ff);
      case (a_action_ff)
         rtf_pkg::ACT_TICK: begin
            if (cycle_inc < {1'b0, cpl_ff}) begin
               cycle_in = cycle_inc[rtf_pkg::CycleW-1:0];
            end else begin
               cycle_in = '0;
               if (line_inc >= {1'b0, lpf_ff}) begin
                  line_in   = '0;
                  frames_in = frames_ff + 1'b1;
                  flag_in   = 1'b1;
               end else begin
                  line_in = line_inc[rtf_pkg::LineW-1:0];
               end
            end
         end
         rtf_pkg::ACT_READ: begin
            if (a_idx_ff == rtf_pkg::RegRaster) begin
               rd_in = line_ff[rtf_pkg::ByteW-1:0];
            end else if (a_idx_ff == rtf_pkg::RegControl) begin
               rd_in = {line_ff[rtf_pkg::LineW-1], reg_base[rtf_pkg::ByteW-2:0]};
            end else begin
               rd_in = reg_base;
            end
         end
         rtf_pkg::ACT_CONSUME: begin
            done_in = flag_ff;
            flag_in = 1'b0;
         end
         default: begin
            rd_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff   <= '0;
         line_ff    <= '0;
         frames_ff  <= '0;
         flag_ff    <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (a_adv) begin
         cycle_ff   <= cycle_in;
         line_ff    <= line_in;
         frames_ff  <= frames_in;
         flag_ff    <= flag_in;
         b_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         b_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         b_rd_ff     <= rd_in;
         b_done_ff   <= done_in;
         b_line_ff   <= line_in;
         b_cycle_ff  <= cycle_in;
         b_frames_ff <= frames_in;
         b_border_ff <= a_border_ff;
         b_bgnd_ff   <= a_bgnd_ff;
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {{(rtf_pkg::RspDataW - rtf_pkg::RspFieldsW){1'b0}},
                        b_bgnd_ff, b_border_ff, b_frames_ff, b_cycle_ff,
                        b_line_ff, b_done_ff, b_rd_ff};

   // The cycle count never reaches the largest 7-bit value, the line count
   // never reaches the largest 9-bit value.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cycle_ff != 7'h7f && line_ff != 9'h1ff)
      else $error("raster counter out of range");

   // A completed frame always leaves the frame flag set.
   a_frame_sets_flag: assert property (@(posedge clock) disable iff (reset)
      !$stable(frames_ff) |-> flag_ff)
      else $error("frame count moved without setting the flag");

   // Input backpressure only when both stages hold an item.
   a_ready_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (a_valid_ff && b_valid_ff && !rsp_tready))
      else $error("request stalled with room available");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench for raster_timing_register_file_core.
// Drives event streams against a cycle-free predictor of the raster counters and
// register file; depends on rtf_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;

   localparam int PadW       = rtf_pkg::RspDataW - rtf_pkg::RspFieldsW;
   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;
   localparam int Settle     = 4;

   typedef struct packed {
      logic [PadW-1:0]            padding;
      logic [rtf_pkg::ColorW-1:0] backdrop_nib;
      logic [rtf_pkg::ColorW-1:0] border_nib;
      logic [rtf_pkg::FrameW-1:0] frame_count;
      logic [rtf_pkg::CycleW-1:0] cycle_now;
      logic [rtf_pkg::LineW-1:0]  line_now;
      logic                       frame_done;
      logic [rtf_pkg::ByteW-1:0]  read_data;
   } raster_result_type;

   typedef struct {
      rtf_pkg::action_type        act;
      logic [rtf_pkg::IndexW-1:0] idx;
      logic [rtf_pkg::ByteW-1:0]  data;
      bit                         typed;
      raster_result_type          result;
   } stim_row_type;

   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [rtf_pkg::ReqDataW-1:0] req_tdata  = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [rtf_pkg::RspDataW-1:0] rsp_tdata;
   logic                         csr_wen    = 1'b0;
   logic                         csr_index  = rtf_pkg::CSR_CYCLES_PER_LINE;
   logic [rtf_pkg::CsrDataW-1:0] csr_wdata  = '0;

   raster_timing_register_file_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predicted state of the raster counters and register file.
   logic [rtf_pkg::ByteW-1:0]  shadow_regs [rtf_pkg::RegDepth];
   logic [rtf_pkg::CycleW-1:0] shadow_cycle;
   logic [rtf_pkg::LineW-1:0]  shadow_line;
   logic [rtf_pkg::FrameW-1:0] shadow_frames;
   logic                       shadow_flag;
   logic [rtf_pkg::CycleW-1:0] cfg_cycles_per_line;
   logic [rtf_pkg::LineW-1:0]  cfg_lines_per_frame;

   raster_result_type expected_results [$];
   stim_row_type      directed_rows [$];

   int send_idle_pct    = 0;
   int stall_pct        = 0;
   int holds_requested  = 0;
   int holds_served     = 0;
   int hold_left        = 0;
   int mismatches       = 0;
   int results_checked  = 0;
   int frame_ends       = 0;
   int directed_events  = 0;
   int random_events    = 0;
   int timing_settings  = 0;
   int unsigned cycle_counter = 0;

   task automatic reset_raster_model();
      for (int i = 0; i < rtf_pkg::RegDepth; i++) shadow_regs[i] = '0;
      shadow_regs[rtf_pkg::RegBorder]     = rtf_pkg::BorderResetValue;
      shadow_regs[rtf_pkg::RegBackground] = rtf_pkg::BackgroundResetValue;
      shadow_cycle        = '0;
      shadow_line         = '0;
      shadow_frames       = '0;
      shadow_flag         = 1'b0;
      cfg_cycles_per_line = rtf_pkg::CyclesPerLineReset;
      cfg_lines_per_frame = rtf_pkg::LinesPerFrameReset;
   endtask

   // Applies one event to the shadow state and returns the result it produces.
   function automatic raster_result_type advance_raster_model(
         input rtf_pkg::action_type act, input logic [rtf_pkg::IndexW-1:0] idx,
         input logic [rtf_pkg::ByteW-1:0] data);
      raster_result_type res;
      int unsigned next_cycle;
      int unsigned next_line;
      res = '0;
      case (act)
         rtf_pkg::ACT_TICK: begin
            next_cycle = shadow_cycle + 1;
            if (next_cycle < cfg_cycles_per_line) begin
               shadow_cycle = next_cycle[rtf_pkg::CycleW-1:0];
            end else begin
               shadow_cycle = '0;
               next_line    = shadow_line + 1;
               // A limit of zero, or one lowered below the count, wraps at once.
               if (next_line >= cfg_lines_per_frame) begin
                  shadow_line   = '0;
                  shadow_frames = shadow_frames + 1;
                  shadow_flag   = 1'b1;
                  frame_ends++;
               end else begin
                  shadow_line = next_line[rtf_pkg::LineW-1:0];
               end
            end
         end
         rtf_pkg::ACT_READ: begin
            if (idx == rtf_pkg::RegRaster)
               res.read_data = shadow_line[7:0];
            else if (idx == rtf_pkg::RegControl)
               res.read_data = {shadow_line[8], shadow_regs[idx][6:0]};
            else
               res.read_data = shadow_regs[idx];
         end
         rtf_pkg::ACT_WRITE: shadow_regs[idx] = data;
         default: begin
            res.frame_done = shadow_flag;
            shadow_flag    = 1'b0;
         end
      endcase
      res.line_now     = shadow_line;
      res.cycle_now    = shadow_cycle;
      res.frame_count  = shadow_frames;
      res.border_nib   = shadow_regs[rtf_pkg::RegBorder][3:0];
      res.backdrop_nib = shadow_regs[rtf_pkg::RegBackground][3:0];
      return res;
   endfunction

   function automatic raster_result_type typed_result(input logic [7:0] rd, input logic done,
         input logic [8:0] line, input logic [6:0] cyc, input logic [31:0] frames,
         input logic [3:0] border, input logic [3:0] backdrop);
      raster_result_type res;
      res = '0;
      res.read_data    = rd;
      res.frame_done   = done;
      res.line_now     = line;
      res.cycle_now    = cyc;
      res.frame_count  = frames;
      res.border_nib   = border;
      res.backdrop_nib = backdrop;
      return res;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
         input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_requested) begin
         holds_served <= holds_served + 1;
         hold_left    <= HoldCycles;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      raster_result_type got;
      raster_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_results.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            check_field("read_data", want.read_data, got.read_data);
            check_field("frame_done", want.frame_done, got.frame_done);
            check_field("line_now", want.line_now, got.line_now);
            check_field("cycle_now", want.cycle_now, got.cycle_now);
            check_field("frame_count", want.frame_count, got.frame_count);
            check_field("border_nib", want.border_nib, got.border_nib);
            check_field("backdrop_nib", want.backdrop_nib, got.backdrop_nib);
            check_field("padding", want.padding, got.padding);
         end
      end
   end

   always @(posedge clock) begin
      cycle_counter++;
      if (cycle_counter > CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_counter, expected_results.size());
         $display("** raster_timing_register_file_core: FAILED **");
         $finish;
      end
   end

   task automatic send_event(input rtf_pkg::action_type act,
         input logic [rtf_pkg::IndexW-1:0] idx, input logic [rtf_pkg::ByteW-1:0] data,
         input bit typed, input raster_result_type typed_res);
      raster_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {data, idx, act};
      do @(posedge clock); while (!req_tready);
      predicted = advance_raster_model(act, idx, data);
      expected_results.push_back(typed ? typed_res : predicted);
   endtask

   // Stops offering events and waits until every expected result has been seen.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   task automatic set_timing(input logic [rtf_pkg::CsrDataW-1:0] cycles_raw,
         input logic [rtf_pkg::CsrDataW-1:0] lines_raw);
      csr_wen   <= 1'b1;
      csr_index <= rtf_pkg::CSR_CYCLES_PER_LINE;
      csr_wdata <= cycles_raw;
      @(posedge clock);
      csr_index <= rtf_pkg::CSR_LINES_PER_FRAME;
      csr_wdata <= lines_raw;
      @(posedge clock);
      csr_wen <= 1'b0;
      cfg_cycles_per_line = cycles_raw[rtf_pkg::CycleW-1:0];
      cfg_lines_per_frame = lines_raw;
      timing_settings++;
   endtask

   task automatic walk_rows(input int first, input int last);
      for (int i = first; i <= last; i++) begin
         send_event(directed_rows[i].act, directed_rows[i].idx, directed_rows[i].data,
                    directed_rows[i].typed, directed_rows[i].result);
         directed_events++;
      end
   endtask

   // Reads and writes lean toward the raster, control and color registers.
   function automatic logic [rtf_pkg::IndexW-1:0] pick_index();
      logic [rtf_pkg::IndexW-1:0] idx;
      if ($urandom_range(0, 99) < 35) begin
         case ($urandom_range(0, 3))
            0:       idx = rtf_pkg::RegControl;
            1:       idx = rtf_pkg::RegRaster;
            2:       idx = rtf_pkg::RegBorder;
            default: idx = rtf_pkg::RegBackground;
         endcase
      end else begin
         idx = rtf_pkg::IndexW'($urandom_range(0, rtf_pkg::RegDepth - 1));
      end
      return idx;
   endfunction

   task automatic run_phase(input int count, input int tick_pct, input int send_pct,
         input int recv_pct, input bit with_pressure);
      rtf_pkg::action_type        act;
      logic [rtf_pkg::IndexW-1:0] idx;
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (with_pressure && i == 40) holds_requested++;
         if (with_pressure && i == 250) drain_results();
         if ($urandom_range(0, 99) < tick_pct) begin
            act = rtf_pkg::ACT_TICK;
            idx = rtf_pkg::IndexW'($urandom);
         end else begin
            case ($urandom_range(0, 2))
               0:       act = rtf_pkg::ACT_READ;
               1:       act = rtf_pkg::ACT_WRITE;
               default: act = rtf_pkg::ACT_CONSUME;
            endcase
            idx = pick_index();
         end
         send_event(act, idx, rtf_pkg::ByteW'($urandom), 1'b0, '0);
         random_events++;
      end
      drain_results();
   endtask

   initial begin
      int split;
      reset_raster_model();

      // Rows up to the split run with the reset timing; the rest with both limits at zero.
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegBorder, 8'h00, 1'b1,
                                typed_result(8'd6, 1'b0, 9'd0, 7'd0, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegBackground, 8'h00, 1'b1,
                                typed_result(8'd14, 1'b0, 9'd0, 7'd0, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_READ, 6'h00, 8'h00, 1'b1,
                                typed_result(8'd0, 1'b0, 9'd0, 7'd0, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_READ, 6'h3f, 8'hff, 1'b1,
                                typed_result(8'd0, 1'b0, 9'd0, 7'd0, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_CONSUME, 6'h3f, 8'hff, 1'b1,
                                typed_result(8'd0, 1'b0, 9'd0, 7'd0, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_TICK, 6'h3f, 8'hff, 1'b1,
                                typed_result(8'd0, 1'b0, 9'd0, 7'd1, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegRaster, 8'h00, 1'b1,
                                typed_result(8'd0, 1'b0, 9'd0, 7'd1, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegControl, 8'h00, 1'b1,
                                typed_result(8'd0, 1'b0, 9'd0, 7'd1, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, rtf_pkg::RegControl, 8'hff, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegControl, 8'h00, 1'b1,
                                typed_result(8'h7f, 1'b0, 9'd0, 7'd1, 32'd0, 4'd6, 4'd14)});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, rtf_pkg::RegRaster, 8'haa, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegRaster, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, rtf_pkg::RegBorder, 8'hff, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, rtf_pkg::RegBackground, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, 6'h3f, 8'hff, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_READ, 6'h3f, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, 6'h00, 8'h55, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_READ, 6'h00, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_WRITE, rtf_pkg::RegBorder, 8'hf0, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegBorder, 8'h00, 1'b0, '0});
      split = directed_rows.size();
      directed_rows.push_back('{rtf_pkg::ACT_TICK, 6'h00, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_CONSUME, 6'h00, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_CONSUME, 6'h00, 8'h00, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_TICK, 6'h15, 8'h5a, 1'b0, '0});
      directed_rows.push_back('{rtf_pkg::ACT_READ, rtf_pkg::RegRaster, 8'h00, 1'b0, '0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      walk_rows(0, split - 1);
      drain_results();
      set_timing(9'd0, 9'd0);
      walk_rows(split, directed_rows.size() - 1);
      drain_results();

      // One cycle per line and the longest frame carry the line past 255.
      set_timing(9'd1, 9'h1ff);
      run_phase(400, 80, 0, 0, 1'b1);
      // The cycle limit drops to zero and the line limit below the running line count here.
      set_timing(9'd0, 9'd3);
      run_phase(350, 55, 55, 0, 1'b0);
      set_timing(9'h1ff, 9'd0);
      run_phase(350, 60, 0, 55, 1'b0);
      set_timing(9'd3, 9'd1);
      run_phase(350, 55, 11, 11, 1'b0);
      set_timing({2'($urandom_range(0, 3)), 7'($urandom_range(1, 8))},
                 9'($urandom_range(1, 20)));
      run_phase(250, 60, 55, 0, 1'b0);
      set_timing({2'b00, rtf_pkg::CyclesPerLineReset}, rtf_pkg::LinesPerFrameReset);
      run_phase(250, 55, 0, 0, 1'b0);

      repeat (10) @(posedge clock);
      $display("Covered %0d directed and %0d random events over %0d timing settings,",
               directed_events, random_events, timing_settings);
      $display("with %0d results checked and %0d frame ends crossed.",
               results_checked, frame_ends);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("** raster_timing_register_file_core: PASSED **");
      end else begin
         $display("** raster_timing_register_file_core: FAILED **");
      end
      $finish;
   end

endmodule
